// ----- hdl/fjt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fjt_pkg
// shared types, character codes and command format of the flat object
// tokenizer
// ----------------------------------------------------------------------------
package fjt_pkg;

    // result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind K_KEY    = 2'd0;
    localparam t_kind K_VALUE  = 2'd1;
    localparam t_kind K_PAIR   = 2'd2;
    localparam t_kind K_FINISH = 2'd3;

    // finish status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_CLOSED   = 2'd0;
    localparam t_status ST_NO_BRACE = 2'd1;
    localparam t_status ST_SYNTAX   = 2'd2;
    localparam t_status ST_TRUNC    = 2'd3;

    // character codes
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // command queue geometry (power of two, pointers wrap naturally)
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = Q_AW + 1;

    typedef enum logic [3:0] {
        PH_START,
        PH_KEY_OR_CLOSE,
        PH_AFTER_VALUE,
        PH_KEY_STR,
        PH_AFTER_KEY,
        PH_VALUE_START,
        PH_VALUE_STR,
        PH_VALUE_PRIM,
        PH_DRAIN
    } t_phase;

    // one classified byte, as handed from front to back
    typedef struct packed {
        logic       push;      // hold a blank, releasing the oldest if full
        logic       flush;     // release held blanks before the byte
        logic       trunc;     // flush at a truncated end, oldest may drop
        logic       has_byte;
        t_kind      byte_kind;
        logic [7:0] data;
        logic       pair;
        logic       fin;
        t_status    status;
    } t_cmd;

    function automatic logic f_is_blank(input logic [7:0] b);
        return b inside {[8'd9:8'd13], CH_SPACE};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/fjt_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fjt interfaces
// valid/ready channels for body bytes and for tokenizer results
// ----------------------------------------------------------------------------
interface fjt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       body_end;

    modport source (output valid, output text_byte, output body_end, input ready);
    modport sink   (input valid, input text_byte, input body_end, output ready);
endinterface

interface fjt_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] finish_status;
    logic       run_last;

    modport source (output valid, output kind, output out_byte, output finish_status,
                    output run_last, input ready);
    modport sink   (input valid, input kind, input out_byte, input finish_status,
                    input run_last, output ready);
endinterface
`default_nettype wire

// ----- hdl/fjt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fjt_front
// accepts body bytes, tracks the parse phase and classifies each byte into
// a command for the back end
// ----------------------------------------------------------------------------
module fjt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fjt_byte_if.sink      i_text,
    input  logic          i_q_full,
    output logic          o_cmd_valid,
    output fjt_pkg::t_cmd o_cmd
);
    import fjt_pkg::*;

    t_phase     r_phase, n_phase, w_case_phase;
    logic       r_esc, n_esc, w_case_esc;
    logic [7:0] w_b;
    logic       w_end;
    logic       w_blank;
    logic       w_accept;
    logic [7:0] w_dec;
    t_cmd       w_cmd;

    // unquoted value byte
    function automatic t_cmd f_prim(input logic [7:0] b, input logic last_byte);
        t_cmd c;
        c      = '0;
        c.data = b;
        if (b == CH_COMMA) begin
            c.pair = 1'b1;
        end else if (b == CH_RBRACE) begin
            c.pair   = 1'b1;
            c.fin    = 1'b1;
            c.status = ST_CLOSED;
        end else if (f_is_blank(b)) begin
            c.push = !last_byte;
        end else begin
            c.flush     = 1'b1;
            c.trunc     = last_byte;
            c.has_byte  = 1'b1;
            c.byte_kind = K_VALUE;
        end
        return c;
    endfunction

    assign i_text.ready = !i_q_full;
    assign w_accept     = i_text.valid && !i_q_full;
    assign w_b          = i_text.text_byte;
    assign w_end        = i_text.body_end;
    assign w_blank      = f_is_blank(w_b);
    assign w_dec        = (w_b == CH_N) ? CH_LF : ((w_b == CH_T) ? CH_TAB : w_b);

    // next state
    always_comb begin
        w_case_phase = r_phase;
        w_case_esc   = r_esc;
        case (r_phase)
            PH_START: begin
                if (w_b == CH_LBRACE) begin
                    w_case_phase = PH_KEY_OR_CLOSE;
                end else if (!w_blank) begin
                    w_case_phase = PH_DRAIN;
                end
            end
            PH_AFTER_VALUE, PH_KEY_OR_CLOSE: begin
                if (r_phase == PH_AFTER_VALUE && w_b == CH_COMMA) begin
                    w_case_phase = PH_KEY_OR_CLOSE;
                end else if (!w_blank) begin
                    if (w_b == CH_QUOTE) begin
                        w_case_phase = PH_KEY_STR;
                    end else if (w_b == CH_COLON) begin
                        w_case_phase = PH_VALUE_START;
                    end else begin
                        w_case_phase = PH_DRAIN;
                    end
                end
            end
            PH_KEY_STR, PH_VALUE_STR: begin
                if (r_esc) begin
                    w_case_esc = 1'b0;
                end else if (w_b == CH_QUOTE) begin
                    w_case_phase = (r_phase == PH_KEY_STR) ? PH_AFTER_KEY : PH_AFTER_VALUE;
                end else if (w_b == CH_BSLASH && !w_end) begin
                    w_case_esc = 1'b1;
                end
            end
            PH_AFTER_KEY: begin
                if (w_b == CH_COLON) begin
                    w_case_phase = PH_VALUE_START;
                end else if (!w_blank) begin
                    w_case_phase = PH_DRAIN;
                end
            end
            PH_VALUE_START, PH_VALUE_PRIM: begin
                if (r_phase == PH_VALUE_START && w_b == CH_QUOTE) begin
                    w_case_phase = PH_VALUE_STR;
                end else if (w_b == CH_COMMA) begin
                    w_case_phase = PH_KEY_OR_CLOSE;
                end else if (w_b == CH_RBRACE) begin
                    w_case_phase = PH_DRAIN;
                end else if (!w_blank) begin
                    w_case_phase = PH_VALUE_PRIM;
                end
            end
            default: begin
                w_case_phase = PH_DRAIN;
            end
        endcase
        n_phase = w_end ? PH_START : w_case_phase;
        n_esc   = w_end ? 1'b0 : w_case_esc;
    end

    // command for the back end
    always_comb begin
        w_cmd      = '0;
        w_cmd.data = w_b;
        case (r_phase)
            PH_START: begin
                if (w_b != CH_LBRACE && !w_blank) begin
                    w_cmd.fin    = 1'b1;
                    w_cmd.status = ST_NO_BRACE;
                end
            end
            PH_AFTER_VALUE, PH_KEY_OR_CLOSE: begin
                if (!(r_phase == PH_AFTER_VALUE && w_b == CH_COMMA) && !w_blank) begin
                    if (w_b == CH_RBRACE) begin
                        w_cmd.fin    = 1'b1;
                        w_cmd.status = ST_CLOSED;
                    end else if (w_b != CH_QUOTE && w_b != CH_COLON) begin
                        w_cmd.fin    = 1'b1;
                        w_cmd.status = ST_SYNTAX;
                    end
                end
            end
            PH_KEY_STR, PH_VALUE_STR: begin
                w_cmd.byte_kind = (r_phase == PH_KEY_STR) ? K_KEY : K_VALUE;
                if (r_esc) begin
                    w_cmd.has_byte = 1'b1;
                    w_cmd.data     = w_dec;
                end else if (w_b == CH_QUOTE) begin
                    w_cmd.pair = (r_phase == PH_VALUE_STR);
                end else if (w_b == CH_BSLASH) begin
                    w_cmd.has_byte = w_end;
                end else begin
                    w_cmd.has_byte = 1'b1;
                end
            end
            PH_AFTER_KEY: begin
                if (w_b != CH_COLON && !w_blank) begin
                    w_cmd.fin    = 1'b1;
                    w_cmd.status = ST_SYNTAX;
                end
            end
            PH_VALUE_START: begin
                if (w_b != CH_QUOTE && !w_blank) begin
                    w_cmd = f_prim(w_b, w_end);
                end
            end
            PH_VALUE_PRIM: begin
                w_cmd = f_prim(w_b, w_end);
            end
            default: begin
                w_cmd.fin = 1'b0;
            end
        endcase
        // end of body
        if (w_end) begin
            if (w_case_phase == PH_START) begin
                w_cmd.fin    = 1'b1;
                w_cmd.status = ST_NO_BRACE;
            end else if (w_case_phase == PH_VALUE_START || w_case_phase == PH_VALUE_STR ||
                         w_case_phase == PH_VALUE_PRIM) begin
                w_cmd.pair   = 1'b1;
                w_cmd.fin    = 1'b1;
                w_cmd.status = ST_TRUNC;
            end else if (w_case_phase != PH_DRAIN) begin
                w_cmd.fin    = 1'b1;
                w_cmd.status = ST_TRUNC;
            end
        end
    end

    assign o_cmd       = w_cmd;
    assign o_cmd_valid = w_accept && (w_cmd.push || w_cmd.has_byte || w_cmd.pair || w_cmd.fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_esc   <= 1'b0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
        end
    end

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_end |=> r_phase == PH_START && !r_esc)
        else $error("body end did not return to start");

endmodule
`default_nettype wire

// ----- hdl/fjt_cmd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fjt_cmd_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
module fjt_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fjt_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output fjt_pkg::t_cmd o_cmd
);
    import fjt_pkg::*;

    t_cmd            r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + Q_CW'(i_push) - Q_CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/fjt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fjt_back
// carries out queued commands: holds trailing blanks, releases them and
// issues one result per unstalled cycle through a registered output stage
// ----------------------------------------------------------------------------
module fjt_back #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  fjt_pkg::t_cmd i_cmd,
    output logic          o_pop,
    fjt_token_if.source   o_token
);
    import fjt_pkg::*;

    localparam int CW    = $clog2(HOLD_DEPTH + 1);
    localparam int PW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int SW    = CW + 1;
    localparam int LIMIT = (HOLD_DEPTH + 1 > 3) ? HOLD_DEPTH + 1 : 3;
    localparam int KEEP  = LIMIT - 3;

    localparam logic [CW-1:0] KEEP_C   = CW'(KEEP);
    localparam logic [CW-1:0] DEPTH_C  = CW'(HOLD_DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(HOLD_DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(HOLD_DEPTH - 1);

    // hold store, circular
    logic [7:0]    r_hold [HOLD_DEPTH];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;

    // progress through the current command
    logic          r_started, n_started;
    logic [CW-1:0] r_left, n_left;
    logic [PW-1:0] r_ptr, n_ptr;
    logic          r_byte_done, n_byte_done;
    logic          r_pair_done, n_pair_done;

    // output stage
    logic          r_o_valid;
    t_kind         r_o_kind;
    logic [7:0]    r_o_byte;
    logic          r_o_mem;
    t_status       r_o_status;
    logic          r_o_last;

    logic          w_adv, w_go, w_full;
    logic [PW-1:0] w_tail, w_start, w_eff_ptr, w_rd_addr;
    logic [CW-1:0] w_keep, w_eff_left;
    logic          w_emit, w_from_mem, w_last, w_done, w_wr;
    t_kind         w_kind;
    logic [7:0]    w_byte;
    t_status       w_status;

    function automatic logic [PW-1:0] f_wrap(input logic [SW-1:0] s);
        return (s >= DEPTH_S) ? PW'(s - DEPTH_S) : PW'(s);
    endfunction

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    assign w_adv      = !r_o_valid || o_token.ready;
    assign w_go       = w_adv && i_cmd_valid;
    assign w_full     = (r_count == DEPTH_C);
    assign w_tail     = f_wrap(SW'(r_head) + SW'(r_count));
    // at a truncated end only the newest blanks are kept
    assign w_keep     = (i_cmd.trunc && r_count > KEEP_C) ? KEEP_C : r_count;
    assign w_start    = f_wrap(SW'(r_head) + SW'(r_count - w_keep));
    assign w_eff_left = r_started ? r_left : (i_cmd.flush ? w_keep : '0);
    assign w_eff_ptr  = r_started ? r_ptr : w_start;

    always_comb begin
        w_emit      = 1'b0;
        w_from_mem  = 1'b0;
        w_kind      = K_VALUE;
        w_byte      = '0;
        w_status    = ST_CLOSED;
        w_last      = 1'b0;
        w_done      = 1'b0;
        w_wr        = 1'b0;
        w_rd_addr   = w_eff_ptr;
        n_head      = r_head;
        n_count     = r_count;
        n_started   = r_started;
        n_left      = r_left;
        n_ptr       = r_ptr;
        n_byte_done = r_byte_done;
        n_pair_done = r_pair_done;
        if (i_cmd.push) begin
            w_emit     = w_full;
            w_from_mem = 1'b1;
            w_rd_addr  = r_head;
            w_last     = 1'b1;
            w_done     = 1'b1;
            w_wr       = 1'b1;
            if (w_full) begin
                n_head = f_inc(r_head);
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            n_started = 1'b1;
            n_left    = w_eff_left;
            n_ptr     = w_eff_ptr;
            if (w_eff_left != '0) begin
                w_emit     = 1'b1;
                w_from_mem = 1'b1;
                w_last     = (w_eff_left == CW'(1)) && !i_cmd.has_byte && !i_cmd.pair &&
                             !i_cmd.fin;
                w_done     = w_last;
                n_left     = w_eff_left - 1'b1;
                n_ptr      = f_inc(w_eff_ptr);
            end else if (i_cmd.has_byte && !r_byte_done) begin
                w_emit      = 1'b1;
                w_kind      = i_cmd.byte_kind;
                w_byte      = i_cmd.data;
                w_last      = !i_cmd.pair && !i_cmd.fin;
                w_done      = w_last;
                n_byte_done = 1'b1;
            end else if (i_cmd.pair && !r_pair_done) begin
                w_emit      = 1'b1;
                w_kind      = K_PAIR;
                w_last      = !i_cmd.fin;
                w_done      = w_last;
                n_pair_done = 1'b1;
            end else begin
                w_emit   = i_cmd.fin;
                w_kind   = K_FINISH;
                w_status = i_cmd.status;
                w_last   = 1'b1;
                w_done   = 1'b1;
            end
        end
        if (w_done) begin
            n_started   = 1'b0;
            n_byte_done = 1'b0;
            n_pair_done = 1'b0;
            if (!i_cmd.push) begin
                n_head  = '0;
                n_count = '0;
            end
        end
    end

    assign o_pop = w_go && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_started   <= 1'b0;
            r_left      <= '0;
            r_ptr       <= '0;
            r_byte_done <= 1'b0;
            r_pair_done <= 1'b0;
        end else if (w_go) begin
            r_head      <= n_head;
            r_count     <= n_count;
            r_started   <= n_started;
            r_left      <= n_left;
            r_ptr       <= n_ptr;
            r_byte_done <= n_byte_done;
            r_pair_done <= n_pair_done;
        end
    end

    // read before write when full: the released byte is the old one
    always_ff @(posedge i_clk) begin
        if (w_go && w_wr) begin
            r_hold[w_tail] <= i_cmd.data;
        end
        if (w_go && w_emit && w_from_mem) begin
            r_rd_data <= r_hold[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_adv) begin
            r_o_valid <= w_go && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_kind   <= w_kind;
            r_o_byte   <= w_byte;
            r_o_mem    <= w_from_mem;
            r_o_status <= w_status;
            r_o_last   <= w_last;
        end
    end

    assign o_token.valid         = r_o_valid;
    assign o_token.kind          = r_o_kind;
    assign o_token.out_byte      = r_o_mem ? r_rd_data : r_o_byte;
    assign o_token.finish_status = r_o_status;
    assign o_token.run_last      = r_o_last;

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_kind == K_FINISH |-> r_o_last)
        else $error("finish result not marked last");

    a_clear_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_cmd.push |=> r_count == '0)
        else $error("held blanks survive the end of a value");

    a_full_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && i_cmd.push && w_full |=> r_count == DEPTH_C)
        else $error("hold store lost its fill on release");

endmodule
`default_nettype wire

// ----- hdl/flat_json_object_tokenizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer
// tokenises a one-level object body into key bytes, value bytes, pair marks
// and a finish status
// ----------------------------------------------------------------------------
//  channel   dir  modport  payload
//  i_text    in   sink     text_byte[7:0], body_end
//  o_token   out  source   kind[1:0], out_byte[7:0], finish_status[1:0], run_last
//
//  a byte transfer is taken in any cycle the four-entry command queue has room
//  the back end gives one result per cycle unless the output stalls; a flush
//  releases one result per held blank, so a byte may yield up to HOLD_DEPTH + 1
//  results; a blank that only enters the hold store yields no result
//  reset is synchronous, active low; the hold store is not cleared (no pass)
//  output stalls back up through the registered output stage into the queue
// ----------------------------------------------------------------------------
module flat_json_object_tokenizer #(
    parameter int HOLD_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fjt_byte_if.sink    i_text,
    fjt_token_if.source o_token
);
    import fjt_pkg::*;

    // front to queue
    logic w_cmd_push;
    t_cmd w_cmd_in;
    logic w_q_full;

    // queue to back
    logic w_cmd_valid;
    t_cmd w_cmd_head;
    logic w_cmd_pop;

    // phase tracking and byte classification
    fjt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text      (i_text),
        .i_q_full    (w_q_full),
        .o_cmd_valid (w_cmd_push),
        .o_cmd       (w_cmd_in)
    );

    // decouples the byte stream from result bursts
    fjt_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_q_full),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_cmd_head)
    );

    // hold store and result sequencing
    fjt_back #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd_head),
        .o_pop       (w_cmd_pop),
        .o_token     (o_token)
    );

endmodule
`default_nettype wire
